FILE: design/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, request codes and character helpers for the integer to ASCII
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

	typedef logic [1:0]  req_type_t;
	typedef logic [63:0] value_t;
	typedef logic [7:0]  char_t;
	typedef logic [3:0]  nibble_t;
	typedef logic [5:0]  count_t;

	localparam req_type_t REQ_SDEC = 2'd0;
	localparam req_type_t REQ_UDEC = 2'd1;
	localparam req_type_t REQ_HEX  = 2'd2;
	localparam req_type_t REQ_NONE = 2'd3;

	localparam int DEC_BITS   = 32;
	localparam int DEC_DIGITS = 10;
	localparam int HEX_DIGITS = 16;

	localparam count_t CNT_DEC_BITS   = count_t'(DEC_BITS);
	localparam count_t CNT_DEC_DIGITS = count_t'(DEC_DIGITS);
	localparam count_t CNT_HEX_DIGITS = count_t'(HEX_DIGITS);

	localparam char_t CHAR_ZERO  = 8'h30;
	localparam char_t CHAR_LOWER = 8'h61;
	localparam char_t CHAR_MINUS = 8'h2d;

	// Nibble to lowercase hex / decimal digit character.
	function automatic char_t nibble_to_char(input nibble_t n);
		if (n < 4'd10) begin
			return CHAR_ZERO + char_t'(n);
		end else begin
			return CHAR_LOWER + char_t'(n) - 8'd10;
		end
	endfunction

endpackage

`default_nettype wire

FILE: design/itoa_if.sv
// ----------------------------------------------------------------------------
// itoa_if
// Valid/ready channels of the integer to ASCII converter: the request channel
// (number and request type) and the character channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface itoa_req_if;
	import itoa_pkg::*;

	logic       valid;
	logic       ready;
	req_type_t  req_type;
	value_t     value;

	modport source (output valid, output req_type, output value, input ready);
	modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface itoa_res_if;
	import itoa_pkg::*;

	logic  valid;
	logic  ready;
	char_t ascii_char;
	logic  last_char;

	modport source (output valid, output ascii_char, output last_char, input ready);
	modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

`default_nettype wire

FILE: design/int_to_ascii_digits.sv
// ----------------------------------------------------------------------------
// int_to_ascii_digits
// Converts a number to its ASCII text, one character per output request,
// most significant first, last character flagged.
// ----------------------------------------------------------------------------
// Each request on req carries a type (signed 32-bit decimal, unsigned 32-bit
// decimal, 64-bit lowercase hex) and a 64-bit value; type 3 is dropped. The
// answer is the text on res, one character per cycle at most, with last_char
// on its final character; zero gives "0" and negative signed values get a
// leading '-'. One number is in work at a time. A hex number steps through all
// 16 nibbles, leading zeros included, and sends no character for a leading
// zero other than the last nibble. A decimal number first runs a bit-serial
// shift-and-add-3 binary to BCD conversion, one bit per cycle over all 32
// bits, then the sign state for a negative value and one step for each of
// the 10 BCD digits. The output register lets the next request be accepted
// while the final character still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_ascii_digits (
	input  wire logic clk,
	input  wire logic arst_n,
	itoa_req_if.sink   req,
	itoa_res_if.source res
);
	import itoa_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CONV = 2'd1;
	localparam logic [1:0] S_SIGN = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0]  state_q;
	count_t      cnt_q;
	logic        neg_q;
	logic        hex_q;
	logic        started_q;
	logic [31:0] bin_q;
	value_t      dig_q;
	logic        out_valid_q;
	char_t       out_char_q;
	logic        out_last_q;

	logic        accept;
	logic        out_free;
	logic        low_neg;
	logic [31:0] low_val;
	value_t      dig_adj;
	nibble_t     top_nib;
	logic        is_last;
	logic        skip;

	assign req.ready      = (state_q == S_IDLE);
	assign accept         = req.valid && req.ready;
	assign out_free       = !out_valid_q || res.ready;
	assign res.valid      = out_valid_q;
	assign res.ascii_char = out_char_q;
	assign res.last_char  = out_last_q;

	assign low_val = req.value[31:0];
	assign low_neg = (req.req_type == REQ_SDEC) && low_val[31];

	assign top_nib = dig_q[63:60];
	assign is_last = (cnt_q == 6'd1);
	assign skip    = !started_q && (top_nib == 4'd0) && !is_last;

	// Add 3 to every BCD digit of 5 or more before the next shift.
	always_comb begin
		for (int i = 0; i < HEX_DIGITS; i++) begin
			if (dig_q[4*i +: 4] >= 4'd5) begin
				dig_adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
			end else begin
				dig_adj[4*i +: 4] = dig_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free && (state_q == S_SIGN || (state_q == S_EMIT && !skip))) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					started_q <= 1'b0;
					if (accept) begin
						unique case (req.req_type)
							REQ_SDEC, REQ_UDEC: begin
								state_q <= S_CONV;
								cnt_q   <= CNT_DEC_BITS;
							end
							REQ_HEX: begin
								state_q <= S_EMIT;
								cnt_q   <= CNT_HEX_DIGITS;
							end
							REQ_NONE: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_CONV: begin
					if (is_last) begin
						state_q <= neg_q ? S_SIGN : S_EMIT;
						cnt_q   <= CNT_DEC_DIGITS;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_SIGN: begin
					if (out_free) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						cnt_q <= cnt_q - 6'd1;
						if (!skip) begin
							started_q <= 1'b1;
						end
						if (is_last) begin
							state_q <= S_IDLE;
						end
					end
				end
			endcase
		end
	end

	// Datapath: magnitude and digit shift registers, output character.
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= low_neg;
			hex_q <= (req.req_type == REQ_HEX);
			bin_q <= low_neg ? (32'd0 - low_val) : low_val;
			dig_q <= (req.req_type == REQ_HEX) ? req.value : '0;
		end else if (state_q == S_CONV) begin
			// BCD digits sit in the top 40 bits, binary bits enter at bit 24.
			dig_q <= {dig_adj[62:24], bin_q[31], 24'd0};
			bin_q <= {bin_q[30:0], 1'b0};
		end else if (state_q == S_EMIT && out_free) begin
			dig_q <= {dig_q[59:0], 4'd0};
		end

		if (state_q == S_SIGN && out_free) begin
			out_char_q <= CHAR_MINUS;
			out_last_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free && !skip) begin
			out_char_q <= nibble_to_char(top_nib);
			out_last_q <= is_last;
		end
	end

	// A character that is not the last one means the number is still in work.
	a_mid_text_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> (state_q != S_IDLE))
		else $error("non-final character pending while idle");

	a_sign_only_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SIGN) |-> neg_q)
		else $error("sign emitted for non-negative value");

	a_bcd_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !hex_q) |-> (top_nib <= 4'd9))
		else $error("BCD digit out of range");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (cnt_q != 6'd0 && cnt_q <= CNT_HEX_DIGITS))
		else $error("digit count out of range");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free && is_last) |=> (out_valid_q && out_last_q))
		else $error("final digit not flagged");

endmodule

`default_nettype wire
